// ===== hdl/sjis_pkg.sv =====
package sjis_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLYPH_GAP     = 3'd0,
		REG_HALF_WIDTH    = 3'd1,
		REG_HALF_HEIGHT   = 3'd2,
		REG_FULL_WIDTH    = 3'd3,
		REG_FULL_HEIGHT   = 3'd4,
		REG_FONTS_PRESENT = 3'd5,
		REG_CANVAS_COLS   = 3'd6,
		REG_CANVAS_ROWS   = 3'd7
	} cfg_idx_t;

	// register reset values
	localparam logic [7:0]  RST_GLYPH_GAP     = 8'd0;
	localparam logic [7:0]  RST_HALF_WIDTH    = 8'd8;
	localparam logic [7:0]  RST_HALF_HEIGHT   = 8'd16;
	localparam logic [7:0]  RST_FULL_WIDTH    = 8'd16;
	localparam logic [7:0]  RST_FULL_HEIGHT   = 8'd16;
	localparam logic [1:0]  RST_FONTS_PRESENT = 2'd3;
	localparam logic [15:0] RST_CANVAS_COLS   = 16'd128;
	localparam logic [15:0] RST_CANVAS_ROWS   = 16'd64;

	// fonts_present bits
	localparam int FONT_HALF_BIT = 0;
	localparam int FONT_FULL_BIT = 1;

	// Shift-JIS lead byte ranges and newline
	localparam logic [7:0] LEAD_A_LO = 8'h81;
	localparam logic [7:0] LEAD_A_HI = 8'h9F;
	localparam logic [7:0] LEAD_B_LO = 8'hE0;
	localparam logic [7:0] LEAD_B_HI = 8'hFC;
	localparam logic [7:0] NEWLINE   = 8'h0A;

	typedef struct packed {
		logic [7:0]  glyph_gap;
		logic [7:0]  half_width;
		logic [7:0]  half_height;
		logic [7:0]  full_width;
		logic [7:0]  full_height;
		logic [1:0]  fonts_present;
		logic [15:0] canvas_cols;
		logic [15:0] canvas_rows;
	} cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic [7:0] ink;
		logic       string_end;
	} text_item_t;

	typedef struct packed {
		logic [15:0] glyph_code;
		logic        is_full;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  glyph_ink;
	} glyph_item_t;

	function automatic logic is_lead(input logic [7:0] b);
		return ((b >= LEAD_A_LO) && (b <= LEAD_A_HI)) ||
		       ((b >= LEAD_B_LO) && (b <= LEAD_B_HI));
	endfunction

endpackage

// ===== hdl/sjis_stream_if.sv =====
interface sjis_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sjis_cfg_regs.sv =====
module sjis_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sjis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sjis_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sjis_pkg::cfg_t                    cfg
);

	sjis_pkg::cfg_t cfg_q;

	// register file, one write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_gap     <= sjis_pkg::RST_GLYPH_GAP;
			cfg_q.half_width    <= sjis_pkg::RST_HALF_WIDTH;
			cfg_q.half_height   <= sjis_pkg::RST_HALF_HEIGHT;
			cfg_q.full_width    <= sjis_pkg::RST_FULL_WIDTH;
			cfg_q.full_height   <= sjis_pkg::RST_FULL_HEIGHT;
			cfg_q.fonts_present <= sjis_pkg::RST_FONTS_PRESENT;
			cfg_q.canvas_cols   <= sjis_pkg::RST_CANVAS_COLS;
			cfg_q.canvas_rows   <= sjis_pkg::RST_CANVAS_ROWS;
		end else if (cfg_we) begin
			unique case (sjis_pkg::cfg_idx_t'(cfg_index))
				sjis_pkg::REG_GLYPH_GAP:     cfg_q.glyph_gap     <= cfg_data[7:0];
				sjis_pkg::REG_HALF_WIDTH:    cfg_q.half_width    <= cfg_data[7:0];
				sjis_pkg::REG_HALF_HEIGHT:   cfg_q.half_height   <= cfg_data[7:0];
				sjis_pkg::REG_FULL_WIDTH:    cfg_q.full_width    <= cfg_data[7:0];
				sjis_pkg::REG_FULL_HEIGHT:   cfg_q.full_height   <= cfg_data[7:0];
				sjis_pkg::REG_FONTS_PRESENT: cfg_q.fonts_present <= cfg_data[1:0];
				sjis_pkg::REG_CANVAS_COLS:   cfg_q.canvas_cols   <= cfg_data[15:0];
				sjis_pkg::REG_CANVAS_ROWS:   cfg_q.canvas_rows   <= cfg_data[15:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/sjis_cursor.sv =====
module sjis_cursor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sjis_pkg::cfg_t         cfg,
	input  logic                   step,
	input  sjis_pkg::text_item_t   item,
	output logic                   emit,
	output sjis_pkg::glyph_item_t  glyph
);

	logic [15:0] col_q, row_q;
	logic [7:0]  lead_q;
	logic        lead_waiting_q, skip_trail_q, stopped_q;

	logic [15:0] col_d, row_d;
	logic [7:0]  lead_d;
	logic        lead_waiting_d, skip_trail_d, stopped_d;

	// decoded action for this byte
	logic        do_place, use_full, do_newline;
	logic [15:0] code;
	logic [7:0]  w, h;

	// placement arithmetic
	logic [16:0] col_sum, row_plus, row_wrap_plus;
	logic        wrap, stop_nowrap, stop_wrap, stop;
	logic [15:0] col_eff, row_eff, col_next;
	logic        half_ok, full_ok, lead;

	assign half_ok = cfg.fonts_present[sjis_pkg::FONT_HALF_BIT];
	assign full_ok = cfg.fonts_present[sjis_pkg::FONT_FULL_BIT];
	assign lead    = sjis_pkg::is_lead(item.text_byte);

	// classify the byte against the pending state
	always_comb begin
		do_place       = 1'b0;
		do_newline     = 1'b0;
		use_full       = 1'b0;
		code           = {8'd0, item.text_byte};
		lead_d         = lead_q;
		lead_waiting_d = lead_waiting_q;
		skip_trail_d   = skip_trail_q;
		priority if (stopped_q) begin
		end else if (skip_trail_q) begin
			skip_trail_d = 1'b0;
		end else if (lead_waiting_q) begin
			lead_waiting_d = 1'b0;
			do_place       = 1'b1;
			use_full       = 1'b1;
			code           = {lead_q, item.text_byte};
		end else if (lead) begin
			priority if (!full_ok) begin
				skip_trail_d = 1'b1;
			end else if (item.string_end) begin
				do_place = 1'b1;
				use_full = 1'b1;
				code     = {item.text_byte, 8'd0};
			end else begin
				lead_d         = item.text_byte;
				lead_waiting_d = 1'b1;
			end
		end else if (half_ok) begin
			if (item.text_byte == sjis_pkg::NEWLINE) begin
				do_newline = 1'b1;
			end else begin
				do_place = 1'b1;
			end
		end
		if (item.string_end) begin
			lead_waiting_d = 1'b0;
			skip_trail_d   = 1'b0;
		end
	end

	assign w = use_full ? cfg.full_width  : cfg.half_width;
	assign h = use_full ? cfg.full_height : cfg.half_height;

	// wrap and stop tests, both row outcomes compared in parallel
	assign col_sum       = {1'b0, col_q} + {9'd0, w};
	assign row_plus      = {1'b0, row_q} + {9'd0, h};
	assign row_wrap_plus = {1'b0, row_plus[15:0]} + {9'd0, h};
	assign wrap          = col_sum > {1'b0, cfg.canvas_cols};
	assign stop_nowrap   = row_plus > {1'b0, cfg.canvas_rows};
	assign stop_wrap     = row_wrap_plus > {1'b0, cfg.canvas_rows};
	assign stop          = wrap ? stop_wrap : stop_nowrap;
	assign col_eff       = wrap ? 16'd0 : col_q;
	assign row_eff       = wrap ? row_plus[15:0] : row_q;
	assign col_next      = wrap ? ({8'd0, w} + {8'd0, cfg.glyph_gap})
	                            : (col_sum[15:0] + {8'd0, cfg.glyph_gap});

	// cursor and stop update
	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		stopped_d = stopped_q;
		if (do_newline) begin
			col_d = 16'd0;
			row_d = row_plus[15:0];
		end else if (do_place) begin
			row_d = row_eff;
			if (stop) begin
				col_d     = col_eff;
				stopped_d = 1'b1;
			end else begin
				col_d = col_next;
			end
		end
		if (item.string_end) begin
			stopped_d = 1'b0;
		end
	end

	assign emit             = do_place && !stop;
	assign glyph.glyph_code = code;
	assign glyph.is_full    = use_full;
	assign glyph.pos_x      = col_eff;
	assign glyph.pos_y      = row_eff;
	assign glyph.glyph_ink  = item.ink;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= 16'd0;
			row_q          <= 16'd0;
			lead_q         <= 8'd0;
			lead_waiting_q <= 1'b0;
			skip_trail_q   <= 1'b0;
			stopped_q      <= 1'b0;
		end else if (step) begin
			col_q          <= col_d;
			row_q          <= row_d;
			lead_q         <= lead_d;
			lead_waiting_q <= lead_waiting_d;
			skip_trail_q   <= skip_trail_d;
			stopped_q      <= stopped_d;
		end
	end

	// a pending lead and a skipped trail never coexist
	a_pending_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(lead_waiting_q && skip_trail_q))
		else $error("lead pending and trail skip both set");

	// a stopped string carries nothing pending
	a_stop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (!lead_waiting_q && !skip_trail_q))
		else $error("pending byte state while stopped");

endmodule

// ===== hdl/sjis_text_layout_cursor.sv =====
// Shift-JIS text layout cursor. Bytes of a string come in on text_in, one item
// per clock cycle when glyph_out keeps up; each byte gives zero or one glyph
// item on glyph_out, valid once the byte has passed the input register and then
// the result register fed by the cursor update logic. The cursor, the pending
// lead byte and the stop flag update in that single pass, so the rate is set
// by the wrap/stop add-and-compare in front of the cursor registers. The cursor
// carries over from one string to the next. The user must write registers through
// cfg_we/cfg_index/cfg_data only while no item is in flight; this is not enforced.
module sjis_text_layout_cursor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sjis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sjis_pkg::CFG_DATA_W-1:0]  cfg_data,
	sjis_stream_if.sink                      text_in,
	sjis_stream_if.source                    glyph_out
);

	sjis_pkg::cfg_t        cfg;
	sjis_pkg::text_item_t  item_s1;
	logic                  valid_s1;
	sjis_pkg::glyph_item_t glyph_d, glyph_q;
	logic                  glyph_valid_q;
	logic                  emit;
	logic                  adv_s1, take_in;

	sjis_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: the stage moves when the result slot is free or being drained
	assign adv_s1        = valid_s1 && (!glyph_valid_q || glyph_out.ready);
	assign take_in       = text_in.valid && text_in.ready;
	assign text_in.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= text_in.data;
		end
	end

	sjis_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (adv_s1),
		.item   (item_s1),
		.emit   (emit),
		.glyph  (glyph_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_valid_q <= 1'b0;
		end else if (adv_s1) begin
			glyph_valid_q <= emit;
		end else if (glyph_out.ready) begin
			glyph_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			glyph_q <= glyph_d;
		end
	end

	assign glyph_out.valid = glyph_valid_q;
	assign glyph_out.data  = glyph_q;

	// a fresh glyph only follows a byte leaving the input stage
	a_glyph_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(glyph_valid_q) |-> $past(adv_s1))
		else $error("glyph raised without a stepped byte");

	// an empty input stage always takes a byte
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> text_in.ready)
		else $error("input stage empty but not ready");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import sjis_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int SETTLE       = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sjis_stream_if #(.T(text_item_t))  text_if ();
	sjis_stream_if #(.T(glyph_item_t)) glyph_if ();

	sjis_text_layout_cursor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text_in   (text_if.sink),
		.glyph_out (glyph_if.source)
	);

	always #4 clk = ~clk;

	// text bytes waiting to be sent
	text_item_t  text_q[$];
	int          bytes_queued;
	int          bytes_taken;

	// layout state as the block should hold it
	cfg_t        lay_cfg;
	logic [15:0] cur_col;
	logic [15:0] cur_row;
	logic [7:0]  lead_hold;
	logic        lead_pend;
	logic        skip_next;
	logic        halted;

	// glyphs laid out but not yet seen on the output
	glyph_item_t pending_glyphs[$];
	int          glyphs_predicted;
	int          mismatches;

	function automatic logic sjis_lead_byte(input logic [7:0] b);
		return (b >= LEAD_A_LO && b <= LEAD_A_HI) || (b >= LEAD_B_LO && b <= LEAD_B_HI);
	endfunction

	// wrap, stop check and cursor advance for one glyph
	function automatic void place_glyph(input logic [7:0] w, input logic [7:0] h,
			input logic [15:0] code, input logic full, input logic [7:0] ink);
		glyph_item_t g;
		if (int'(cur_col) + int'(w) > int'(lay_cfg.canvas_cols)) begin
			cur_row = cur_row + 16'(h);
			cur_col = '0;
		end
		if (int'(cur_row) + int'(h) > int'(lay_cfg.canvas_rows)) begin
			halted = 1'b1;
			return;
		end
		g.glyph_code = code;
		g.is_full    = full;
		g.pos_x      = cur_col;
		g.pos_y      = cur_row;
		g.glyph_ink  = ink;
		pending_glyphs.push_back(g);
		glyphs_predicted++;
		cur_col = cur_col + 16'(w) + 16'(lay_cfg.glyph_gap);
	endfunction

	function automatic void lay_out_byte(input text_item_t it);
		logic [7:0] b;
		b = it.text_byte;
		if (!halted) begin
			if (skip_next) begin
				skip_next = 1'b0;
			end else if (lead_pend) begin
				// trail byte taken as is
				lead_pend = 1'b0;
				place_glyph(lay_cfg.full_width, lay_cfg.full_height, {lead_hold, b}, 1'b1,
					it.ink);
			end else if (sjis_lead_byte(b)) begin
				if (!lay_cfg.fonts_present[FONT_FULL_BIT])
					skip_next = 1'b1;
				else if (it.string_end)
					place_glyph(lay_cfg.full_width, lay_cfg.full_height, {b, 8'h00}, 1'b1,
						it.ink);
				else begin
					lead_hold = b;
					lead_pend = 1'b1;
				end
			end else if (lay_cfg.fonts_present[FONT_HALF_BIT]) begin
				if (b == NEWLINE) begin
					cur_row = cur_row + 16'(lay_cfg.half_height);
					cur_col = '0;
				end else
					place_glyph(lay_cfg.half_width, lay_cfg.half_height, {8'h00, b}, 1'b0,
						it.ink);
			end
		end
		if (it.string_end) begin
			halted    = 1'b0;
			lead_pend = 1'b0;
			skip_next = 1'b0;
		end
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.data  <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			busy = text_if.valid;
			if (text_if.valid && text_if.ready) begin
				lay_out_byte(text_if.data);
				bytes_taken++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0 || text_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					text_if.valid <= 1'b0;
				end else begin
					text_if.valid <= 1'b1;
					text_if.data  <= text_q.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) :
							$urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end
		end
	end

	// receiver: checks each glyph and stalls on a rotating pattern
	logic [15:0] stall_pat;
	int          pat_left;

	function automatic void report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t: %s expected %h got %h", $time, name, want, got);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		glyph_item_t want;
		glyph_item_t got;
		if (!arst_n) begin
			glyph_if.ready <= 1'b0;
			stall_pat = '0;
			pat_left  = 0;
		end else begin
			if (glyph_if.valid && glyph_if.ready) begin
				got = glyph_if.data;
				if (pending_glyphs.size() == 0) begin
					$display("%0t: glyph expected none got %p", $time, got);
					mismatches++;
				end else begin
					want = pending_glyphs.pop_front();
					if (got.glyph_code !== want.glyph_code)
						report_field("glyph_code", want.glyph_code, got.glyph_code);
					if (got.is_full !== want.is_full)
						report_field("is_full", 16'(want.is_full), 16'(got.is_full));
					if (got.pos_x !== want.pos_x)
						report_field("pos_x", want.pos_x, got.pos_x);
					if (got.pos_y !== want.pos_y)
						report_field("pos_y", want.pos_y, got.pos_y);
					if (got.glyph_ink !== want.glyph_ink)
						report_field("glyph_ink", 16'(want.glyph_ink), 16'(got.glyph_ink));
				end
			end
			if (pat_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = 16'hFFFF;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'h00FF;
					default: stall_pat = 16'($urandom) | 16'($urandom);
				endcase
				pat_left = 32;
			end
			glyph_if.ready <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			pat_left--;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic [7:0] ink, input logic last);
		text_item_t it;
		it.text_byte  = b;
		it.ink        = ink;
		it.string_end = last;
		text_q.push_back(it);
		bytes_queued++;
	endtask

	// one string: mostly well-formed text, some noise
	task automatic queue_string(input int len);
		int k;
		int roll;
		logic [7:0] b;
		k = 0;
		if ($urandom_range(0, 9) == 0) begin
			for (k = 0; k < len; k++)
				queue_byte(8'($urandom), 8'($urandom),
					(k == len - 1) || ($urandom_range(0, 7) == 0));
		end else begin
			while (k < len) begin
				roll = $urandom_range(0, 99);
				if (roll < 25 || (k == len - 1 && roll < 35)) begin
					// lead byte, then any trail unless the string ends here
					b = $urandom_range(0, 1) ? 8'($urandom_range(LEAD_A_LO, LEAD_A_HI)) :
						8'($urandom_range(LEAD_B_LO, LEAD_B_HI));
					queue_byte(b, 8'($urandom), k == len - 1);
					k++;
					if (k < len) begin
						queue_byte(8'($urandom), 8'($urandom), k == len - 1);
						k++;
					end
				end else begin
					if (roll < 35)
						b = NEWLINE;
					else if (roll < 80)
						b = 8'($urandom_range(8'h20, 8'h7E));
					else begin
						do
							b = 8'($urandom);
						while (sjis_lead_byte(b) || b == NEWLINE);
					end
					queue_byte(b, 8'($urandom), k == len - 1);
					k++;
				end
			end
		end
	endtask

	task automatic queue_text(input int n);
		int cnt;
		int len;
		cnt = 0;
		while (cnt < n) begin
			len = $urandom_range(1, 20);
			queue_string(len);
			cnt += len;
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_GLYPH_GAP:     lay_cfg.glyph_gap     = val[7:0];
			REG_HALF_WIDTH:    lay_cfg.half_width    = val[7:0];
			REG_HALF_HEIGHT:   lay_cfg.half_height   = val[7:0];
			REG_FULL_WIDTH:    lay_cfg.full_width    = val[7:0];
			REG_FULL_HEIGHT:   lay_cfg.full_height   = val[7:0];
			REG_FONTS_PRESENT: lay_cfg.fonts_present = val[1:0];
			REG_CANVAS_COLS:   lay_cfg.canvas_cols   = val;
			REG_CANVAS_ROWS:   lay_cfg.canvas_rows   = val;
			default: ;
		endcase
	endtask

	// all eight registers, junk in the unused upper bits
	task automatic program_layout(input logic [7:0] gap, input logic [7:0] hw,
			input logic [7:0] hh, input logic [7:0] fw, input logic [7:0] fh,
			input logic [1:0] fonts, input logic [15:0] cols, input logic [15:0] rows);
		write_reg(REG_GLYPH_GAP,     {8'($urandom), gap});
		write_reg(REG_HALF_WIDTH,    {8'($urandom), hw});
		write_reg(REG_HALF_HEIGHT,   {8'($urandom), hh});
		write_reg(REG_FULL_WIDTH,    {8'($urandom), fw});
		write_reg(REG_FULL_HEIGHT,   {8'($urandom), fh});
		write_reg(REG_FONTS_PRESENT, {14'($urandom), fonts});
		write_reg(REG_CANVAS_COLS,   cols);
		write_reg(REG_CANVAS_ROWS,   rows);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// all bytes taken, all glyphs seen, then let the pipeline drain
	task automatic wait_idle();
		do
			@(negedge clk);
		while (bytes_taken != bytes_queued || pending_glyphs.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int p;
		int n;
		int items_done;
		int r;
		logic [1:0] fonts;
		logic [15:0] cols;
		logic [15:0] rows;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		text_if.valid  = 1'b0;
		text_if.data   = '0;
		glyph_if.ready = 1'b0;
		lay_cfg = '{RST_GLYPH_GAP, RST_HALF_WIDTH, RST_HALF_HEIGHT, RST_FULL_WIDTH,
			RST_FULL_HEIGHT, RST_FONTS_PRESENT, RST_CANVAS_COLS, RST_CANVAS_ROWS};
		cur_col          = '0;
		cur_row          = '0;
		lead_hold        = '0;
		lead_pend        = 1'b0;
		skip_next        = 1'b0;
		halted           = 1'b0;
		bytes_queued     = 0;
		bytes_taken      = 0;
		glyphs_predicted = 0;
		mismatches       = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: boundary bytes, both lead ranges, wrap, stop
		queue_byte(8'h41, 8'h00, 1'b0);
		queue_byte(8'h00, 8'hFF, 1'b0);
		queue_byte(8'hFF, 8'h5A, 1'b0);
		queue_byte(8'h80, 8'hA5, 1'b0);
		queue_byte(8'hA0, 8'h01, 1'b0);
		queue_byte(8'hDF, 8'h80, 1'b0);
		queue_byte(8'hFD, 8'h7F, 1'b0);
		queue_byte(LEAD_A_LO, 8'h11, 1'b0);
		queue_byte(8'h40, 8'h22, 1'b0);
		queue_byte(LEAD_A_HI, 8'h33, 1'b0);
		queue_byte(8'hFC, 8'h44, 1'b0);
		queue_byte(LEAD_B_LO, 8'h55, 1'b0);
		queue_byte(8'h00, 8'h66, 1'b0);
		queue_byte(LEAD_B_HI, 8'h77, 1'b0);
		queue_byte(8'hFF, 8'h88, 1'b0);
		queue_byte(8'h7E, 8'h99, 1'b0);
		// lead byte closing the string, wraps to the next line
		queue_byte(8'h88, 8'hAA, 1'b1);
		queue_byte(NEWLINE, 8'hBB, 1'b0);
		queue_byte(NEWLINE, 8'hCC, 1'b0);
		queue_byte(8'h31, 8'hDD, 1'b0);
		queue_byte(NEWLINE, 8'hEE, 1'b0);
		// off the bottom: rest of the string dropped
		queue_byte(8'h32, 8'h12, 1'b0);
		queue_byte(8'h82, 8'h34, 1'b0);
		queue_byte(8'h33, 8'h56, 1'b1);
		wait_idle();

		// half font missing: newline and half bytes dropped
		program_layout(RST_GLYPH_GAP, RST_HALF_WIDTH, RST_HALF_HEIGHT, RST_FULL_WIDTH,
			RST_FULL_HEIGHT, 2'(1 << FONT_FULL_BIT), RST_CANVAS_COLS, 16'hFFFF);
		queue_byte(NEWLINE, 8'h01, 1'b0);
		queue_byte(8'h41, 8'h02, 1'b0);
		queue_byte(8'h89, 8'h03, 1'b0);
		queue_byte(8'h50, 8'h04, 1'b1);
		wait_idle();

		// full font missing: lead and its trail dropped
		program_layout(RST_GLYPH_GAP, RST_HALF_WIDTH, RST_HALF_HEIGHT, RST_FULL_WIDTH,
			RST_FULL_HEIGHT, 2'(1 << FONT_HALF_BIT), RST_CANVAS_COLS, 16'hFFFF);
		queue_byte(8'h89, 8'h05, 1'b0);
		queue_byte(NEWLINE, 8'h06, 1'b0);
		queue_byte(8'h41, 8'h07, 1'b1);
		wait_idle();

		// random phases, each with its own settings
		p = 0;
		items_done = 0;
		while (items_done < RANDOM_ITEMS && p < 60) begin
			n = $urandom_range(60, 140);
			fonts = ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'b11;
			r = int'(cur_row) + $urandom_range(0, 400);
			if (r > 65535)
				r = 65535;
			rows = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'(r);
			case ($urandom_range(0, 3))
				0: cols = 16'($urandom_range(1, 30));
				1: cols = 16'hFFFF;
				default: cols = 16'($urandom_range(1, 700));
			endcase
			case (p)
				0: program_layout(8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 2'b11, 16'd1, 16'hFFFF);
				1: program_layout(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 2'b11, 16'hFFFF,
					16'hFFFF);
				// zero glyph sizes
				2: program_layout(8'($urandom_range(0, 3)), 8'd0, 8'd0, 8'd0, 8'd0, 2'b11,
					16'($urandom_range(1, 300)), 16'(r));
				// zero canvas: nothing fits
				3: begin
					program_layout(8'($urandom), 8'($urandom_range(1, 16)),
						8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
						8'($urandom_range(1, 16)), 2'b11, 16'd0, 16'd0);
					n = 20;
				end
				// tall glyphs that always wrap, run the row past 16 bits
				4: begin
					program_layout(8'($urandom), 8'd255, 8'd255, 8'd255, 8'd255, 2'b11,
						16'($urandom_range(1, 254)), 16'hFFFF);
					n = (65536 - int'(cur_row)) / 255 + 12;
				end
				5: begin
					program_layout(8'($urandom_range(0, 12)), 8'($urandom_range(1, 24)),
						8'($urandom_range(1, 32)), 8'($urandom_range(1, 40)),
						8'($urandom_range(1, 40)), 2'b00, cols, rows);
					n = 40;
				end
				default:
					program_layout(($urandom_range(0, 7) == 0) ? 8'd255 :
						8'($urandom_range(0, 12)),
						8'($urandom_range(1, 24)), 8'($urandom_range(1, 32)),
						8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
						fonts, cols, rows);
			endcase
			queue_text(n);
			items_done += n;
			wait_idle();
			p++;
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// generous overall limit
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
